// ----- hdl/utf8_codepoint_decoder_assert.svh -----
// Assertion macros shared by the UTF-8 decoder modules.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U8CD_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("u8cd assertion failed");

// Next-cycle implication, checked out of reset.
`define U8CD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("u8cd assertion failed");

`endif

// ----- hdl/u8cd_pkg.sv -----
// Types and constants of the UTF-8 code point decoder.
// No dependencies; compiled before every other file.
package u8cd_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int CP_BITS         = 21;
    localparam int OUT_OFFSET_BITS = 16;
    localparam int LEN_BITS        = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CP_BITS-1:0]  REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [LEN_BITS-1:0] LEN_ONE        = 3'd1;

    localparam logic [1:0] CONT_TAG = 2'b10;

    // Compact description of the results caused by one input byte:
    // flush_n replacements at consecutive offsets, then an optional tail result.
    typedef struct packed {
        logic [1:0]          flush_n;
        logic                tail_valid;
        logic [CP_BITS-1:0]  tail_cp;
        logic [LEN_BITS-1:0] tail_len;
    } u8cd_desc_t;

endpackage

// ----- hdl/u8cd_ifs.sv -----
// Valid/ready channel interfaces of the UTF-8 decoder: byte stream in,
// code point stream out. Depends on u8cd_pkg.
interface u8cd_in_if;
    import u8cd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] text_byte;
    logic                 final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8cd_out_if;
    import u8cd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CP_BITS-1:0]         code_point;
    logic [OUT_OFFSET_BITS-1:0] start_offset;
    logic [LEN_BITS-1:0]        byte_length;
    logic                       run_end;

    modport source (output valid, output code_point, output start_offset,
                    output byte_length, output run_end, input ready);
    modport sink   (input valid, input code_point, input start_offset,
                    input byte_length, input run_end, output ready);
endinterface

// ----- hdl/u8cd_front.sv -----
// Front end: accepts bytes, tracks the open sequence and emits one
// result descriptor per byte that yields results. Depends on u8cd_pkg.
module u8cd_front #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    u8cd_in_if.sink                 text,
    input  logic                    full,
    output logic                    push,
    output u8cd_pkg::u8cd_desc_t    desc,
    output logic [OFFSET_BITS-1:0]  flush_start,
    output logic [OFFSET_BITS-1:0]  tail_start
);
    import u8cd_pkg::*;

    logic [CP_BITS-1:0]     acc_reg, acc_next;
    logic [1:0]             need_reg, need_next;
    logic [1:0]             taken_reg, taken_next;
    logic [OFFSET_BITS-1:0] seq_reg, seq_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    logic [BYTE_BITS-1:0] b;
    logic                 accept;
    logic                 lead_path;
    logic [CP_BITS-1:0]   acc_shift;
    logic [1:0]           need_dec;
    logic [1:0]           taken_inc;

    assign b          = text.text_byte;
    assign text.ready = !full;
    assign accept     = text.valid && text.ready;
    assign push       = accept && (desc.flush_n != 2'd0 || desc.tail_valid);

    assign acc_shift = {acc_reg[CP_BITS-7:0], b[5:0]};
    assign need_dec  = need_reg - 2'd1;
    assign taken_inc = taken_reg + 2'd1;

    always_comb
    begin
        desc        = '0;
        flush_start = seq_reg;
        tail_start  = pos_reg;
        acc_next    = acc_reg;
        need_next   = need_reg;
        taken_next  = taken_reg;
        seq_next    = seq_reg;
        lead_path   = 1'b0;

        if (need_reg == 2'd0)
        begin
            lead_path = 1'b1;
        end
        else if (b[7:6] == CONT_TAG)
        begin
            acc_next   = acc_shift;
            need_next  = need_dec;
            taken_next = taken_inc;
            if (need_dec == 2'd0)
            begin
                desc.tail_valid = 1'b1;
                desc.tail_cp    = acc_shift;
                desc.tail_len   = {1'b0, taken_inc} + LEN_ONE;
                tail_start      = seq_reg;
                acc_next        = '0;
                taken_next      = 2'd0;
            end
            else if (text.final_byte)
            begin
                desc.flush_n = taken_inc + 2'd1;
            end
        end
        else
        begin
            // broken sequence: replace lead and taken bytes, then restart
            desc.flush_n = taken_inc;
            acc_next     = '0;
            need_next    = 2'd0;
            taken_next   = 2'd0;
            lead_path    = 1'b1;
        end

        if (lead_path)
        begin
            if (b inside {8'b0???_????})
            begin
                desc.tail_valid = 1'b1;
                desc.tail_cp    = {{(CP_BITS-BYTE_BITS){1'b0}}, b};
                desc.tail_len   = LEN_ONE;
            end
            else if (b inside {8'b110?_????, 8'b1110_????, 8'b1111_0???})
            begin
                seq_next   = pos_reg;
                taken_next = 2'd0;
                if (b[5] == 1'b0)
                begin
                    need_next = 2'd1;
                    acc_next  = {{(CP_BITS-5){1'b0}}, b[4:0]};
                end
                else if (b[4] == 1'b0)
                begin
                    need_next = 2'd2;
                    acc_next  = {{(CP_BITS-4){1'b0}}, b[3:0]};
                end
                else
                begin
                    need_next = 2'd3;
                    acc_next  = {{(CP_BITS-3){1'b0}}, b[2:0]};
                end
                // truncated right at the lead
                if (text.final_byte)
                begin
                    desc.tail_valid = 1'b1;
                    desc.tail_cp    = REPLACEMENT_CP;
                    desc.tail_len   = LEN_ONE;
                end
            end
            else
            begin
                desc.tail_valid = 1'b1;
                desc.tail_cp    = REPLACEMENT_CP;
                desc.tail_len   = LEN_ONE;
            end
        end

        if (text.final_byte)
        begin
            acc_next   = '0;
            need_next  = 2'd0;
            taken_next = 2'd0;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            need_reg  <= 2'd0;
            taken_reg <= 2'd0;
            seq_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            acc_reg   <= acc_next;
            need_reg  <= need_next;
            taken_reg <= taken_next;
            seq_reg   <= seq_next;
            pos_reg   <= pos_next;
        end
    end

`include "utf8_codepoint_decoder_assert.svh"

    `U8CD_ASSERT_NOW(a_idle_no_taken, need_reg == 2'd0, taken_reg == 2'd0)
    `U8CD_ASSERT_NOW(a_seq_len, need_reg != 2'd0, ({1'b0, need_reg} + {1'b0, taken_reg}) <= 3'd3)
    `U8CD_ASSERT_NEXT(a_final_closes, accept && text.final_byte, pos_reg == '0 && need_reg == 2'd0)

endmodule

// ----- hdl/u8cd_queue.sv -----
// Short register FIFO between the front and back ends.
// Depends on u8cd_pkg for its depth.
module u8cd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             nonempty
);
    import u8cd_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full     = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign rdata    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = (wr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        rd_next  = (rd_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_next;
            end
            if (do_pop)
            begin
                rd_reg <= rd_next;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hdl/u8cd_back.sv -----
// Back end: expands each descriptor into one to four results and holds
// them in an output register. Depends on u8cd_pkg.
module u8cd_back #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  u8cd_pkg::u8cd_desc_t    desc,
    input  logic [OFFSET_BITS-1:0]  flush_start,
    input  logic [OFFSET_BITS-1:0]  tail_start,
    output logic                    pop,
    u8cd_out_if.source              points
);
    import u8cd_pkg::*;

    logic [1:0]                 idx_reg;
    logic                       out_valid_reg;
    logic [CP_BITS-1:0]         cp_reg;
    logic [OUT_OFFSET_BITS-1:0] start_reg;
    logic [LEN_BITS-1:0]        len_reg;
    logic                       end_reg;

    logic                       load;
    logic [2:0]                 total;
    logic                       in_flush;
    logic                       cur_last;
    logic [CP_BITS-1:0]         cur_cp;
    logic [OFFSET_BITS-1:0]     cur_start;
    logic [OUT_OFFSET_BITS-1:0] cur_start16;
    logic [LEN_BITS-1:0]        cur_len;

    assign total    = {1'b0, desc.flush_n} + {2'b00, desc.tail_valid};
    assign in_flush = (idx_reg < desc.flush_n);
    assign cur_last = ({1'b0, idx_reg} + 3'd1 == total);
    assign load     = q_valid && (!out_valid_reg || points.ready);
    assign pop      = load && cur_last;

    always_comb
    begin
        if (in_flush)
        begin
            cur_cp    = REPLACEMENT_CP;
            cur_start = flush_start + {{(OFFSET_BITS-2){1'b0}}, idx_reg};
            cur_len   = LEN_ONE;
        end
        else
        begin
            cur_cp    = desc.tail_cp;
            cur_start = tail_start;
            cur_len   = desc.tail_len;
        end
    end

    generate
        if (OFFSET_BITS >= OUT_OFFSET_BITS)
        begin : g_trunc
            assign cur_start16 = cur_start[OUT_OFFSET_BITS-1:0];
        end
        else
        begin : g_extend
            assign cur_start16 = {{(OUT_OFFSET_BITS-OFFSET_BITS){1'b0}}, cur_start};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= cur_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (points.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg    <= cur_cp;
            start_reg <= cur_start16;
            len_reg   <= cur_len;
            end_reg   <= cur_last;
        end
    end

    assign points.valid        = out_valid_reg;
    assign points.code_point   = cp_reg;
    assign points.start_offset = start_reg;
    assign points.byte_length  = len_reg;
    assign points.run_end      = end_reg;

`include "utf8_codepoint_decoder_assert.svh"

    `U8CD_ASSERT_NOW(a_desc_nonempty, q_valid, desc.flush_n != 2'd0 || desc.tail_valid)
    `U8CD_ASSERT_NOW(a_idx_in_range, q_valid, {1'b0, idx_reg} < total)
    `U8CD_ASSERT_NEXT(a_head_kept, load && !cur_last, q_valid && idx_reg != 2'd0)

endmodule

// ----- hdl/utf8_codepoint_decoder.sv -----
// Channel   | Dir | Payload                                          | Request
// ----------+-----+--------------------------------------------------+----------------
// text      | in  | text_byte[7:0], final_byte                       | one text byte
// points    | out | code_point[20:0], start_offset[15:0],            | one code point
//           |     | byte_length[2:0], run_end                        |
//
// One byte per cycle in steady state; a result is registered in the descriptor queue,
// then in the output register. A byte yields 0 to 4 results; the back end emits one
// result per cycle while points is ready, so malformed input that expands to several
// results stalls the byte side once the two-entry descriptor queue fills.
// rst_n is asynchronous, active low, and clears sequence state and offsets.
// Either side may stall freely; the queue and output register decouple them.
//
// Top level of the UTF-8 code point decoder. Depends on u8cd_pkg, u8cd_ifs,
// u8cd_front, u8cd_queue and u8cd_back.
module utf8_codepoint_decoder #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    u8cd_in_if.sink     text,
    u8cd_out_if.source  points
);
    import u8cd_pkg::*;

    localparam int DESC_BITS = $bits(u8cd_desc_t);
    localparam int Q_BITS    = DESC_BITS + 2 * OFFSET_BITS;

    logic                   push, pop, full, nonempty;
    u8cd_desc_t             f_desc, b_desc;
    logic [OFFSET_BITS-1:0] f_flush_start, f_tail_start;
    logic [OFFSET_BITS-1:0] b_flush_start, b_tail_start;
    logic [Q_BITS-1:0]      q_wdata, q_rdata;

    u8cd_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text),
        .full        (full),
        .push        (push),
        .desc        (f_desc),
        .flush_start (f_flush_start),
        .tail_start  (f_tail_start)
    );

    assign q_wdata = {f_desc, f_flush_start, f_tail_start};

    u8cd_queue #(.WIDTH(Q_BITS)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (q_wdata),
        .pop      (pop),
        .rdata    (q_rdata),
        .full     (full),
        .nonempty (nonempty)
    );

    assign {b_desc, b_flush_start, b_tail_start} = q_rdata;

    u8cd_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (nonempty),
        .desc        (b_desc),
        .flush_start (b_flush_start),
        .tail_start  (b_tail_start),
        .pop         (pop),
        .points      (points)
    );

endmodule
